FILE: rtl/core/lpr_pkg.sv
package lpr_pkg;

    // Widths of the position, trigger and loop-mode fields.
    localparam int POS_W     = 32;
    localparam int TRIG_W    = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [MODE_W-1:0]    mode_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_START_POS  = 3'd0;
    localparam cfg_idx_t CFG_END_POS    = 3'd1;
    localparam cfg_idx_t CFG_LOOP_MODE  = 3'd2;
    localparam cfg_idx_t CFG_LOOP_START = 3'd3;
    localparam cfg_idx_t CFG_LOOP_END   = 3'd4;

    // Loop modes. The unused fourth code behaves as ping-pong.
    localparam mode_t MODE_CLIP     = 2'd0;
    localparam mode_t MODE_WRAP     = 2'd1;
    localparam mode_t MODE_PINGPONG = 2'd2;

endpackage

FILE: rtl/core/looping_phase_ramp.sv
// Sample playback phasor with clip, forward-wrap and ping-pong loop modes.
// The sample channel (sample_valid, sample_stall, trigger_sample, step_rate)
// takes one item per audio sample; an item is taken when sample_valid is high
// and sample_stall is low. The position channel (position_valid,
// position_stall, position) returns one item per sample: the Q16.16 position
// before this sample's step. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes start_pos, end_pos, loop_mode,
// loop_start and loop_end; it is always ready. The user must use it only
// while idle; the block itself does not enforce this. An item passes through
// the emit, add and step states, and its result is written to the output
// register in the emit state. A rising trigger first passes through the
// shared bit-serial divider, which works out the sub-sample trigger fraction.
// A wrap in mode 1 then uses the same divider to compute the modulo.
// The block takes a new item only when idle, after the last item's step.
// The result sits in an output register; a stalled receiver holds it, and the
// block can still take and work on the next item until that item's own
// result is ready to be written.
// Reset clears the configuration, the position and the previous trigger to
// zero and sets the ping-pong direction to forward.
module looping_phase_ramp
    import lpr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [POS_W-1:0]         cfg_data,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic signed [TRIG_W-1:0] trigger_sample,
    input  logic signed [POS_W-1:0]  step_rate,
    output logic                     position_valid,
    input  logic                     position_stall,
    output logic signed [POS_W-1:0]  position
);

    // Fraction is unsigned Q1.FRACTION_BITS so that it may reach exactly one.
    localparam int FRAC_W = FRACTION_BITS + 1;
    // Numerator of the fraction: a positive trigger shifted up.
    localparam int NUM_W  = TRIG_W - 1 + FRACTION_BITS;
    // Magnitude of the distance from the wrap base.
    localparam int MAG_W  = POS_W + 1;
    localparam int DVD_W  = (NUM_W > MAG_W) ? NUM_W : MAG_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int PROD_W = FRAC_W + 1 + POS_W;
    localparam int STEP_W = POS_W + 2;
    localparam int WIDE_W = POS_W + 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAC,
        S_RELOAD,
        S_EMIT,
        S_ADD,
        S_STEP,
        S_WRAP,
        S_MOD,
        S_FIX
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [POS_W-1:0] start_pos_reg;
    logic signed [POS_W-1:0] end_pos_reg;
    mode_t                   loop_mode_reg;
    logic signed [POS_W-1:0] loop_start_reg;
    logic signed [POS_W-1:0] loop_end_reg;

    // Playback state.
    logic signed [POS_W-1:0]  pos_reg;
    logic signed [TRIG_W-1:0] prev_trig_reg;
    logic                     back_reg;

    // Per-item working registers.
    logic signed [POS_W-1:0]  rate_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [STEP_W-1:0] x_reg;
    logic signed [STEP_W:0]   diff_reg;
    logic signed [POS_W-1:0]  wrap_lo_reg;
    logic [POS_W-1:0]         wrap_range_reg;

    // Output register.
    logic signed [POS_W-1:0] out_pos_reg;
    logic                    out_valid_reg;

    // Shared divider.
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_bits;
    logic [POS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [POS_W-1:0] div_rem;

    logic                     accept;
    logic                     trig;
    logic signed [TRIG_W:0]   den;
    logic                     rev;
    logic                     lrev;
    logic signed [POS_W-1:0]  lo;
    logic signed [POS_W-1:0]  hi;
    logic                     in_loop;
    logic                     use_minus;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [WIDE_W-1:0] reload_sum;
    logic signed [STEP_W:0]   mag_full;
    logic [POS_W-1:0]         mod_adj;

    logic signed [STEP_W-1:0] st_e;
    logic signed [STEP_W-1:0] en_e;
    logic signed [STEP_W-1:0] ls_e;
    logic signed [STEP_W-1:0] le_e;
    logic signed [STEP_W-1:0] lo_e;
    logic signed [STEP_W-1:0] hi_e;

    logic signed [STEP_W-1:0] step_next;
    logic                     back_next;
    logic                     wrap_next;
    logic signed [POS_W-1:0]  wrap_lo_next;
    logic signed [POS_W-1:0]  wrap_hi_next;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-POS_W:0] top;
        logic signed [POS_W-1:0] r;
        top = v[WIDE_W-1:POS_W-1];
        if (top == '0 || top == '1)
        begin
            r = v[POS_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    assign cfg_ready      = 1'b1;
    assign sample_stall   = (state_reg != S_IDLE);
    assign accept         = sample_valid && !sample_stall;
    assign position_valid = out_valid_reg;
    assign position       = out_pos_reg;

    // A rising trigger crosses from at or below zero to above zero.
    assign trig = (prev_trig_reg <= 0) && (trigger_sample > 0);
    assign den  = (TRIG_W+1)'(trigger_sample) - (TRIG_W+1)'(prev_trig_reg);

    // Orderings of the play range and of the loop points pick the branches.
    assign rev     = end_pos_reg < start_pos_reg;
    assign lrev    = loop_end_reg < loop_start_reg;
    assign lo      = lrev ? loop_end_reg : loop_start_reg;
    assign hi      = lrev ? loop_start_reg : loop_end_reg;
    assign in_loop = (pos_reg >= lo) && (pos_reg <= hi);

    assign st_e = STEP_W'(start_pos_reg);
    assign en_e = STEP_W'(end_pos_reg);
    assign ls_e = STEP_W'(loop_start_reg);
    assign le_e = STEP_W'(loop_end_reg);
    assign lo_e = STEP_W'(lo);
    assign hi_e = STEP_W'(hi);

    // Direction of this sample's step, before any bound is applied.
    always_comb
    begin
        case (loop_mode_reg)
            MODE_CLIP:
            begin
                use_minus = rev;
            end
            MODE_WRAP:
            begin
                if (rev && lrev)
                begin
                    use_minus = 1'b1;
                end
                else if (rev)
                begin
                    use_minus = !in_loop;
                end
                else if (lrev)
                begin
                    use_minus = in_loop;
                end
                else
                begin
                    use_minus = 1'b0;
                end
            end
            default:
            begin
                use_minus = in_loop ? back_reg : rev;
            end
        endcase
    end

    // Bounds applied to the stepped position.
    always_comb
    begin
        step_next    = x_reg;
        back_next    = back_reg;
        wrap_next    = 1'b0;
        wrap_lo_next = loop_start_reg;
        wrap_hi_next = loop_end_reg;
        case (loop_mode_reg)
            MODE_CLIP:
            begin
                if (rev)
                begin
                    if (x_reg < en_e)
                    begin
                        step_next = en_e;
                    end
                    else if (x_reg > st_e)
                    begin
                        step_next = st_e;
                    end
                end
                else
                begin
                    if (x_reg < st_e)
                    begin
                        step_next = st_e;
                    end
                    else if (x_reg > en_e)
                    begin
                        step_next = en_e;
                    end
                end
            end
            MODE_WRAP:
            begin
                if (rev && lrev)
                begin
                    if (x_reg < ls_e)
                    begin
                        wrap_next    = 1'b1;
                        wrap_lo_next = loop_end_reg;
                        wrap_hi_next = loop_start_reg;
                    end
                end
                else if (rev)
                begin
                    if (in_loop)
                    begin
                        if (x_reg > le_e)
                        begin
                            step_next = ls_e;
                        end
                    end
                    else if (x_reg < ls_e)
                    begin
                        step_next = le_e;
                    end
                end
                else if (lrev)
                begin
                    if (in_loop)
                    begin
                        if (x_reg < le_e)
                        begin
                            step_next = ls_e;
                        end
                    end
                    else if (x_reg > ls_e)
                    begin
                        step_next = ls_e;
                    end
                end
                else if (x_reg > le_e)
                begin
                    wrap_next = 1'b1;
                end
            end
            default:
            begin
                if (in_loop)
                begin
                    if (x_reg < lo_e)
                    begin
                        step_next = lo_e;
                        back_next = 1'b0;
                    end
                    else if (x_reg > hi_e)
                    begin
                        step_next = hi_e;
                        back_next = 1'b1;
                    end
                end
                else if (rev)
                begin
                    if (x_reg < lo_e)
                    begin
                        step_next = lrev ? ls_e : le_e;
                    end
                end
                else if (x_reg > hi_e)
                begin
                    step_next = ls_e;
                end
            end
        endcase
    end

    // Reload offset: floor(frac * rate / 2^FRACTION_BITS), saturated sum.
    assign prod_sh    = prod_reg >>> FRACTION_BITS;
    assign reload_sum = WIDE_W'(start_pos_reg) + WIDE_W'(prod_sh);

    // Wrap: mathematical modulo of the distance from the loop base.
    assign mag_full = diff_reg[STEP_W] ? -diff_reg : diff_reg;
    assign mod_adj  = (diff_reg[STEP_W] && div_rem != '0) ? (wrap_range_reg - div_rem)
                                                          : div_rem;

    // The divider serves the trigger fraction on accept and the wrap later on.
    assign div_start    = (accept && trig) ||
                          (state_reg == S_WRAP && wrap_range_reg != '0);
    assign div_dividend = (state_reg == S_IDLE)
        ? (DVD_W'(trigger_sample[TRIG_W-2:0]) << (DVD_W - (TRIG_W - 1)))
        : (DVD_W'(mag_full[MAG_W-1:0]) << (DVD_W - MAG_W));
    assign div_bits     = (state_reg == S_IDLE) ? CNT_W'(NUM_W) : CNT_W'(MAG_W);
    assign div_divisor  = (state_reg == S_IDLE) ? POS_W'(den[TRIG_W-1:0]) : wrap_range_reg;

    lpr_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .bits      (div_bits),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg  <= '0;
            end_pos_reg    <= '0;
            loop_mode_reg  <= MODE_CLIP;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_POS:  start_pos_reg  <= cfg_data;
                CFG_END_POS:    end_pos_reg    <= cfg_data;
                CFG_LOOP_MODE:  loop_mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_LOOP_START: loop_start_reg <= cfg_data;
                CFG_LOOP_END:   loop_end_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer with the playback state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            prev_trig_reg <= '0;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The output register fills in the emit state once it is free or
            // being taken, and empties when the receiver takes its item.
            if (state_reg == S_EMIT && (!out_valid_reg || !position_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !position_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_trig_reg <= trigger_sample;
                        state_reg     <= trig ? S_FRAC : S_EMIT;
                    end
                end
                S_FRAC:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RELOAD;
                    end
                end
                S_RELOAD:
                begin
                    pos_reg <= sat_pos(reload_sum);
                    // A trigger sets the ping-pong direction by the play range, else by the loop points.
                    if (loop_mode_reg != MODE_CLIP && loop_mode_reg != MODE_WRAP)
                    begin
                        if (rev)
                        begin
                            back_reg <= 1'b1;
                        end
                        else if (lrev)
                        begin
                            back_reg <= 1'b0;
                        end
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !position_stall)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    back_reg  <= back_next;
                    if (wrap_next)
                    begin
                        state_reg <= S_WRAP;
                    end
                    else
                    begin
                        pos_reg   <= sat_pos(WIDE_W'(step_next));
                        state_reg <= S_IDLE;
                    end
                end
                S_WRAP:
                begin
                    // An empty loop range wraps onto its single point.
                    if (wrap_range_reg == '0)
                    begin
                        pos_reg   <= wrap_lo_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    pos_reg   <= POS_W'(wrap_lo_reg) + mod_adj;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rate_reg <= step_rate;
        end
        if (state_reg == S_FRAC && div_done)
        begin
            prod_reg <= $signed({1'b0, div_quo[FRAC_W-1:0]}) * rate_reg;
        end
        if (state_reg == S_EMIT && (!out_valid_reg || !position_stall))
        begin
            out_pos_reg <= pos_reg;
        end
        if (state_reg == S_ADD)
        begin
            x_reg <= use_minus ? (STEP_W'(pos_reg) - STEP_W'(rate_reg))
                               : (STEP_W'(pos_reg) + STEP_W'(rate_reg));
        end
        if (state_reg == S_STEP)
        begin
            diff_reg       <= (STEP_W+1)'(x_reg) - (STEP_W+1)'(wrap_lo_next);
            wrap_lo_reg    <= wrap_lo_next;
            wrap_range_reg <= POS_W'(wrap_hi_next) - POS_W'(wrap_lo_next);
        end
    end

endmodule

FILE: rtl/core/lpr_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module lpr_div
    import lpr_pkg::*;
#(
    parameter int DVD_W = 33,
    localparam int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CNT_W-1:0] bits,
    input  logic [POS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [POS_W-1:0] remainder
);

    logic [DVD_W-1:0] dvd_reg;
    logic [POS_W-1:0] rem_reg;
    logic [POS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [POS_W:0]   shifted;
    logic [POS_W+1:0] trial;
    logic             qbit;

    // The dividend is left aligned, so its top bit enters the remainder first.
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign qbit    = ~trial[POS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= bits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
            rem_reg <= qbit ? trial[POS_W-1:0] : shifted[POS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

FILE: tb/sv/tb_looping_phase_ramp.sv
`timescale 1ns / 100ps

module tb_looping_phase_ramp;
    import lpr_pkg::*;

    // The block is built with the default fraction width, and the predictor
    // below uses the same one.
    localparam int FRAC_BITS = 16;

    // Reset holds for this many clocks, and the block is given this many
    // clocks to finish a trailing modulo before registers are rewritten.
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 100;

    // Random part: phases of fresh settings and idling patterns.
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 94;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 400;

    // Register indexes that the block does not decode, and the spare loop
    // mode code that must act as ping-pong.
    localparam cfg_idx_t CFG_NONE_LO = 3'd5;
    localparam cfg_idx_t CFG_NONE_HI = 3'd7;
    localparam mode_t    MODE_SPARE  = 2'd3;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_idx_t                 cfg_index = CFG_START_POS;
    logic [POS_W-1:0]         cfg_data = '0;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    logic signed [TRIG_W-1:0] trigger_sample = '0;
    logic signed [POS_W-1:0]  step_rate = '0;
    logic                     position_valid;
    logic                     position_stall = 1'b0;
    logic signed [POS_W-1:0]  position;

    looping_phase_ramp #(
        .FRACTION_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .trigger_sample(trigger_sample),
        .step_rate(step_rate),
        .position_valid(position_valid),
        .position_stall(position_stall),
        .position(position)
    );

    always #1 clk = ~clk;

    // The predictor keeps its own copy of the settings and of the ramp state.
    // All of it matches the block right after reset.
    logic signed [31:0] set_start_pos = '0;
    logic signed [31:0] set_end_pos = '0;
    mode_t              set_mode = MODE_CLIP;
    logic signed [31:0] set_loop_start = '0;
    logic signed [31:0] set_loop_end = '0;
    logic signed [31:0] ramp_pos = '0;
    logic signed [15:0] ramp_prev_trig = '0;
    bit                 ramp_backward = 1'b0;

    // Positions still owed by the block, oldest first.
    logic signed [31:0] pending_positions[$];

    int fail_count = 0;
    int samples_sent = 0;
    int positions_checked = 0;
    int trigger_reloads = 0;
    int reg_writes = 0;

    // Idling controls. The percentages are the chance, per clock, that the
    // sender holds back an item or the receiver stalls. A nonzero hold-off
    // makes the receiver stall for that many clocks in a row.
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_left = 0;

    // Each row of the directed part either writes one register or sends one
    // item. Where the expected position is obvious it is typed into the row.
    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;
    typedef struct {
        row_kind_t          kind;
        cfg_idx_t           widx;
        logic [31:0]        wdata;
        logic signed [15:0] trig;
        logic signed [31:0] rate;
        bit                 typed;
        logic signed [31:0] want;
    } ramp_row_t;

    localparam int NUM_ROWS = 43;

    ramp_row_t directed_rows [NUM_ROWS] = '{
        // Reset settings clip everything to zero. A trigger rising from zero
        // has a full fraction, so the reload shows the rate itself.
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd0, 32'sh7FFF_FFFF, 1'b1, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd32767, 32'sh7FFF_FFFF, 1'b1,
          32'sh7FFF_FFFF},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sh8000, 32'sh8000_0000, 1'b1, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd32767, 32'sh8000_0000, 1'b0, 32'sh0},
        // Reversed clip range with a reload that overflows and saturates.
        '{ROW_WRITE, CFG_START_POS, 32'h7FFF_FFFF, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_END_POS, 32'h8000_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd1, 32'sh1, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd32767, 32'sh7FFF_FFFF, 1'b1,
          32'sh7FFF_FFFF},
        // Forward wrap with both loop points equal: the wrap lands on them.
        '{ROW_WRITE, CFG_START_POS, 32'h0, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_END_POS, 32'h0010_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_MODE, 32'(MODE_WRAP), 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_START, 32'h0004_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_END, 32'h0004_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd0, 32'sh0003_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd7, 32'sh0003_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd2, 32'sh0003_0000, 1'b0, 32'sh0},
        // Loop points in reverse order under the wrap mode.
        '{ROW_WRITE, CFG_LOOP_START, 32'h0008_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_END, 32'h0002_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd5, 32'sh0005_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd5, 32'sh0005_0000, 1'b0, 32'sh0},
        // Ping-pong with a reversed start/end: a trigger turns it backward.
        '{ROW_WRITE, CFG_START_POS, 32'h0010_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_END_POS, 32'h0, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_MODE, 32'(MODE_PINGPONG), 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_START, 32'h0002_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_END, 32'h0006_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd100, 32'sh0001_8000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd200, 32'sh0001_8000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd10, 32'sh0002_8000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd10, 32'sh0002_8000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd10, 32'sh0002_8000, 1'b0, 32'sh0},
        // The spare mode code with reversed loop points: a trigger turns the
        // ramp forward.
        '{ROW_WRITE, CFG_START_POS, 32'h0, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_END_POS, 32'h0010_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_MODE, 32'(MODE_SPARE), 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_START, 32'h0006_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_LOOP_END, 32'h0002_0000, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, -16'sd3, 32'sh0001_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd3, 32'sh0003_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd5, 32'sh0003_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd5, 32'sh0003_0000, 1'b0, 32'sh0},
        // Writes to undecoded indexes must leave the start position at zero,
        // which a trigger with a zero rate then shows.
        '{ROW_WRITE, CFG_NONE_LO, 32'hFFFF_FFFF, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_WRITE, CFG_NONE_HI, 32'h1234_5678, 16'sd0, 32'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd0, 32'sh0001_0000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, CFG_START_POS, 32'h0, 16'sd32767, 32'sh0, 1'b1, 32'sh0}
    };

    logic signed [31:0] extreme_rates [5] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh1, -32'sh1
    };

    function automatic longint clamp(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Folds x into the half-open range from lo to hi. An empty range gives lo.
    function automatic longint wrap_into(longint x, longint lo, longint hi);
        longint span;
        longint m;
        span = hi - lo;
        if (span <= 0)
            return lo;
        m = (x - lo) % span;
        if (m < 0)
            m += span;
        return lo + m;
    endfunction

    // Works out the position the block shows for one sample and then steps
    // the predicted ramp exactly as the block should.
    function automatic logic signed [31:0] advance_ramp(logic signed [15:0] trig,
                                                        logic signed [31:0] rate_in);
        longint cur, rate, lv, st, en, ls, le, lo, hi, frac, stepped;
        bit rev, lrev;
        logic signed [31:0] shown;
        cur  = longint'(trig);
        rate = longint'(rate_in);
        lv   = longint'(ramp_pos);
        st   = longint'(set_start_pos);
        en   = longint'(set_end_pos);
        ls   = longint'(set_loop_start);
        le   = longint'(set_loop_end);
        rev  = en < st;
        lrev = le < ls;

        // A zero crossing upward restarts the ramp at the start position,
        // advanced by the share of the sample that lies past the crossing.
        if (ramp_prev_trig <= 0 && cur > 0) begin
            frac = (cur << FRAC_BITS) / (cur - longint'(ramp_prev_trig));
            lv = clamp(st + ((frac * rate) >>> FRAC_BITS), POS_MIN, POS_MAX);
            trigger_reloads++;
            if (set_mode >= MODE_PINGPONG) begin
                if (rev)
                    ramp_backward = 1'b1;
                else if (lrev)
                    ramp_backward = 1'b0;
            end
        end
        shown = lv[31:0];

        if (set_mode == MODE_CLIP) begin
            lv = rev ? clamp(lv - rate, en, st) : clamp(lv + rate, st, en);
        end else if (set_mode == MODE_WRAP) begin
            if (rev) begin
                if (lrev) begin
                    lv -= rate;
                    if (lv < ls)
                        lv = wrap_into(lv, le, ls);
                end else if (lv >= ls && lv <= le) begin
                    lv += rate;
                    if (lv > le)
                        lv = ls;
                end else begin
                    lv -= rate;
                    if (lv < ls)
                        lv = le;
                end
            end else if (lrev) begin
                if (lv >= le && lv <= ls) begin
                    lv -= rate;
                    if (lv < le)
                        lv = ls;
                end else begin
                    lv += rate;
                    if (lv > ls)
                        lv = ls;
                end
            end else begin
                lv += rate;
                if (lv > le)
                    lv = wrap_into(lv, ls, le);
            end
        end else begin
            lo = lrev ? le : ls;
            hi = lrev ? ls : le;
            if (lv >= lo && lv <= hi) begin
                // Inside the loop the ramp bounces off either end.
                lv += ramp_backward ? -rate : rate;
                if (lv < lo) begin
                    lv = lo;
                    ramp_backward = 1'b0;
                end else if (lv > hi) begin
                    lv = hi;
                    ramp_backward = 1'b1;
                end
            end else if (rev) begin
                lv -= rate;
                if (lv < lo)
                    lv = lrev ? ls : le;
            end else begin
                lv += rate;
                if (lv > hi)
                    lv = ls;
            end
        end

        stepped = clamp(lv, POS_MIN, POS_MAX);
        ramp_pos = stepped[31:0];
        ramp_prev_trig = trig;
        return shown;
    endfunction

    function automatic logic signed [31:0] point_near(logic signed [31:0] center);
        return center + (int'($urandom_range(32'h20_0000)) - 32'sh10_0000);
    endfunction

    // Writes one register and mirrors the write into the predictor. The valid
    // drops for a clock afterwards, so back-to-back writes never lower and
    // raise it within one step.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_START_POS:  set_start_pos = data;
            CFG_END_POS:    set_end_pos = data;
            CFG_LOOP_MODE:  set_mode = data[MODE_W-1:0];
            CFG_LOOP_START: set_loop_start = data;
            CFG_LOOP_END:   set_loop_end = data;
            default:        ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one sample item, idling first when the sender pattern says so.
    // The expected position is queued at the edge where the item is taken.
    task automatic send_sample(input logic signed [15:0] trig,
                               input logic signed [31:0] rate,
                               input bit typed, input logic signed [31:0] want);
        logic signed [31:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid   <= 1'b1;
        trigger_sample <= trig;
        step_rate      <= rate;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predicted = advance_ramp(trig, rate);
        pending_positions.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    // Stops offering items, waits for every owed position, then gives the
    // block time to finish any modulo that trails the last result.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Receiver: checks every position item taken and decides the stall for
    // the next clock. A hold-off request is counted down here, one clock at a
    // time, so the sender keeps pushing while the block backs up.
    initial begin : position_checker
        logic signed [31:0] expected_pos;
        forever begin
            @(posedge clk);
            if (rst_n && position_valid && !position_stall) begin
                if (pending_positions.size() == 0) begin
                    $error("position: expected nothing, got %0d", position);
                    fail_count++;
                end else begin
                    expected_pos = pending_positions.pop_front();
                    positions_checked++;
                    if (position !== expected_pos) begin
                        $error("position: expected %0d, got %0d", expected_pos, position);
                        fail_count++;
                    end
                end
            end
            if (hold_off_left > 0) begin
                position_stall <= 1'b1;
                hold_off_left--;
            end else begin
                position_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Stimulus: reset, the directed table, then the random phases.
    initial begin : stimulus
        ramp_row_t          row;
        bit                 after_sample;
        int                 phase;
        int                 sent_in_phase;
        int                 run_left;
        bit                 noisy;
        logic signed [15:0] trig;
        logic signed [31:0] rate;
        logic signed [31:0] center;
        logic signed [31:0] new_start, new_end, new_ls, new_le;
        mode_t              new_mode;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // The directed table runs with no idling on either side. Before a
        // register write the block is drained so it is idle.
        after_sample = 1'b0;
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                if (after_sample)
                    wait_idle();
                write_reg(row.widx, row.wdata);
                after_sample = 1'b0;
            end else begin
                send_sample(row.trig, row.rate, row.typed, row.want);
                after_sample = 1'b1;
            end
        end

        // Random phases. The first three use extreme settings; the rest draw
        // loop points around a common center so that ramps with moderate
        // rates actually reach the bounds, and now and then pure noise.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    new_start = 32'sh8000_0000;
                    new_end   = 32'sh7FFF_FFFF;
                    new_mode  = MODE_CLIP;
                    new_ls    = 32'sh8000_0000;
                    new_le    = 32'sh7FFF_FFFF;
                end
                1: begin
                    new_start = 32'sh7FFF_FFFF;
                    new_end   = 32'sh8000_0000;
                    new_mode  = MODE_PINGPONG;
                    new_ls    = 32'sh7FFF_FFFF;
                    new_le    = 32'sh8000_0000;
                end
                2: begin
                    new_start = 32'sh7FFF_FFFF;
                    new_end   = 32'sh8000_0000;
                    new_mode  = MODE_WRAP;
                    new_ls    = 32'sh8000_0000;
                    new_le    = 32'sh7FFF_FFFF;
                end
                default: begin
                    new_mode = mode_t'($urandom_range(3));
                    if ($urandom_range(3) == 0) begin
                        new_start = $urandom;
                        new_end   = $urandom;
                        new_ls    = $urandom;
                        new_le    = $urandom;
                    end else begin
                        center    = int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
                        new_start = point_near(center);
                        new_end   = point_near(center);
                        new_ls    = point_near(center);
                        new_le    = point_near(center);
                    end
                end
            endcase
            write_reg(CFG_START_POS, new_start);
            write_reg(CFG_END_POS, new_end);
            write_reg(CFG_LOOP_MODE, 32'(new_mode));
            write_reg(CFG_LOOP_START, new_ls);
            write_reg(CFG_LOOP_END, new_le);
            if ($urandom_range(2) == 0)
                write_reg(cfg_idx_t'($urandom_range(CFG_NONE_HI, CFG_NONE_LO)), $urandom);

            // Four idling patterns in turn: none, a mostly idle sender, a
            // mostly stalling receiver, and light idling on both sides.
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            if (phase == PRESSURE_PHASE)
                hold_off_left = HOLD_OFF_CYCLES;

            // Most of the stream is ramps: a run of non-positive trigger
            // samples closed by one positive sample, so each run ends in a
            // reload. One run in five is unstructured trigger noise.
            sent_in_phase = 0;
            run_left = 0;
            noisy = 1'b0;
            while (sent_in_phase < ITEMS_PER_PHASE) begin
                if (run_left == 0) begin
                    noisy = ($urandom_range(4) == 0);
                    run_left = $urandom_range(40, 3);
                end
                run_left--;
                if (noisy)
                    trig = 16'($urandom);
                else if (run_left == 0)
                    trig = 16'($urandom_range(32767, 1));
                else
                    trig = 16'(-int'($urandom_range(32768)));
                case ($urandom_range(19))
                    0:       rate = extreme_rates[$urandom_range(4)];
                    1, 2:    rate = $urandom;
                    3, 4, 5: rate = int'($urandom_range(32'h4000)) - 32'sh2000;
                    default: rate = int'($urandom_range(32'h4_0000)) - 32'sh2_0000;
                endcase
                send_sample(trig, rate, 1'b0, 32'sh0);
                sent_in_phase++;
            end
        end

        wait_idle();
        $display("Sent %0d samples with %0d trigger reloads over %0d register writes;",
                 samples_sent, trigger_reloads, reg_writes);
        $display("compared %0d positions across clip, wrap and ping-pong settings.",
                 positions_checked);
        if (fail_count == 0)
            $display("tb_looping_phase_ramp OK");
        else
            $display("tb_looping_phase_ramp NOT OK");
        $finish;
    end

    // Hard limit on the run: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("tb_looping_phase_ramp NOT OK");
        $finish;
    end

endmodule
